// File: sv/ssched_pkg.sv
`timescale 1ns / 1ps
// Package for the settle and backoff send scheduler.
// Holds shared types, status codes, register indexes and reset values; no dependencies.
package ssched_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int MS_W        = 24;
    localparam int VALUE_W     = 32;
    localparam int NOW_W       = 32;
    localparam int CODE_W      = 11;
    localparam int STATUS_W    = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_MS      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKOFF_INIT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKOFF_MAX    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DESTINATION    = 2'd3;

    localparam logic [MS_W-1:0] RST_SETTLE_MS    = 24'd2000;
    localparam logic [MS_W-1:0] RST_BACKOFF_INIT = 24'd1000;
    localparam logic [MS_W-1:0] RST_BACKOFF_MAX  = 24'd60000;
    localparam logic            RST_DESTINATION  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_IDLE        = 4'd0;
    localparam logic [STATUS_W-1:0] ST_SETTLING    = 4'd1;
    localparam logic [STATUS_W-1:0] ST_BACKING_OFF = 4'd2;
    localparam logic [STATUS_W-1:0] ST_LINK_DOWN   = 4'd3;
    localparam logic [STATUS_W-1:0] ST_DROPPED     = 4'd4;
    localparam logic [STATUS_W-1:0] ST_OPEN_FAILED = 4'd5;
    localparam logic [STATUS_W-1:0] ST_SENT_OK     = 4'd6;
    localparam logic [STATUS_W-1:0] ST_BAD_REPLY   = 4'd7;
    localparam logic [STATUS_W-1:0] ST_QUEUED      = 4'd8;

    localparam logic ACT_QUEUE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    localparam logic signed [CODE_W-1:0] CODE_OK_LOW  = 11'sd200;
    localparam logic signed [CODE_W-1:0] CODE_OK_HIGH = 11'sd300;

    typedef struct packed {
        logic [MS_W-1:0] settle_ms;
        logic [MS_W-1:0] backoff_initial_ms;
        logic [MS_W-1:0] backoff_max_ms;
        logic            destination_set;
    } cfg_t;

    typedef struct packed {
        logic                      action;
        logic [NOW_W-1:0]          now_ms;
        logic [VALUE_W-1:0]        value_word;
        logic                      link_up;
        logic                      open_ok;
        logic signed [CODE_W-1:0]  response_code;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                attempt;
        logic [VALUE_W-1:0]  send_value;
        logic                pending;
        logic [MS_W-1:0]     backoff_now_ms;
    } result_t;

endpackage

// File: sv/ssched_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the scheduler's input and result beats.
// Depends on ssched_pkg for field widths.
interface ssched_item_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    action;
    logic [ssched_pkg::NOW_W-1:0]            now_ms;
    logic [ssched_pkg::VALUE_W-1:0]          value_word;
    logic                                    link_up;
    logic                                    open_ok;
    logic signed [ssched_pkg::CODE_W-1:0]    response_code;

    modport source (output valid, action, now_ms, value_word, link_up, open_ok,
                    response_code, input ready);
    modport sink (input valid, action, now_ms, value_word, link_up, open_ok,
                  response_code, output ready);
endinterface

interface ssched_result_if;
    logic                              valid;
    logic                              ready;
    logic [ssched_pkg::STATUS_W-1:0]   status;
    logic                              attempt;
    logic [ssched_pkg::VALUE_W-1:0]    send_value;
    logic                              pending;
    logic [ssched_pkg::MS_W-1:0]       backoff_now_ms;

    modport source (output valid, status, attempt, send_value, pending, backoff_now_ms,
                    input ready);
    modport sink (input valid, status, attempt, send_value, pending, backoff_now_ms,
                  output ready);
endinterface

// File: sv/ssched_cfg.sv
`timescale 1ns / 1ps
// Configuration register file of the scheduler, written through a plain write port.
// Depends on ssched_pkg for the register indexes, reset values and cfg_t.
module ssched_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ssched_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ssched_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ssched_pkg::cfg_t                    cfg
);

    ssched_pkg::cfg_t cfg_reg;
    ssched_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ssched_pkg::REG_SETTLE_MS:    cfg_next.settle_ms = cfg_data;
                ssched_pkg::REG_BACKOFF_INIT: cfg_next.backoff_initial_ms = cfg_data;
                ssched_pkg::REG_BACKOFF_MAX:  cfg_next.backoff_max_ms = cfg_data;
                ssched_pkg::REG_DESTINATION:  cfg_next.destination_set = cfg_data[0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_ms          <= ssched_pkg::RST_SETTLE_MS;
            cfg_reg.backoff_initial_ms <= ssched_pkg::RST_BACKOFF_INIT;
            cfg_reg.backoff_max_ms     <= ssched_pkg::RST_BACKOFF_MAX;
            cfg_reg.destination_set    <= ssched_pkg::RST_DESTINATION;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/ssched_core.sv
`timescale 1ns / 1ps
// Scheduler state and single-pass decision logic for one beat.
// Depends on ssched_pkg for cfg_t, item_t, result_t and the status codes.
module ssched_core
#(
    parameter int TIME_WIDTH = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  ssched_pkg::item_t   item,
    input  ssched_pkg::cfg_t    cfg,
    output ssched_pkg::result_t result
);

    localparam int MS_W  = ssched_pkg::MS_W;
    localparam int EXT_W = TIME_WIDTH + ssched_pkg::NOW_W;
    localparam int SUM_W = TIME_WIDTH + MS_W;

    logic                           pending_reg;
    logic                           pending_next;
    logic [ssched_pkg::VALUE_W-1:0] held_reg;
    logic [ssched_pkg::VALUE_W-1:0] held_next;
    logic [TIME_WIDTH-1:0]          settle_dl_reg;
    logic [TIME_WIDTH-1:0]          settle_dl_next;
    logic [TIME_WIDTH-1:0]          retry_dl_reg;
    logic [TIME_WIDTH-1:0]          retry_dl_next;
    logic [MS_W-1:0]                backoff_reg;
    logic [MS_W-1:0]                backoff_next;

    logic [EXT_W-1:0]               now_ext;
    logic [TIME_WIDTH-1:0]          now_t;
    logic [SUM_W-1:0]               settle_sum;
    logic [SUM_W-1:0]               retry_sum;
    logic [TIME_WIDTH-1:0]          settle_diff;
    logic [TIME_WIDTH-1:0]          retry_diff;
    logic                           settle_wait;
    logic                           retry_wait;
    logic [MS_W:0]                  doubled;
    logic [MS_W-1:0]                capped;
    logic                           reply_ok;
    logic [ssched_pkg::STATUS_W-1:0] status;
    logic                           attempt;

    // Time is carried modulo 2^TIME_WIDTH; a negative difference means not yet.
    assign now_ext     = {{TIME_WIDTH{1'b0}}, item.now_ms};
    assign now_t       = now_ext[TIME_WIDTH-1:0];
    assign settle_sum  = {{MS_W{1'b0}}, now_t} + {{TIME_WIDTH{1'b0}}, cfg.settle_ms};
    assign retry_sum   = {{MS_W{1'b0}}, now_t} + {{TIME_WIDTH{1'b0}}, backoff_reg};
    assign settle_diff = now_t - settle_dl_reg;
    assign retry_diff  = now_t - retry_dl_reg;
    assign settle_wait = settle_diff[TIME_WIDTH-1];
    assign retry_wait  = retry_diff[TIME_WIDTH-1];
    assign doubled     = {backoff_reg, 1'b0};
    assign capped      = (doubled > {1'b0, cfg.backoff_max_ms}) ? cfg.backoff_max_ms
                                                                : doubled[MS_W-1:0];
    assign reply_ok    = (item.response_code >= ssched_pkg::CODE_OK_LOW) &&
                         (item.response_code < ssched_pkg::CODE_OK_HIGH);

    always_comb
    begin
        pending_next   = pending_reg;
        held_next      = held_reg;
        settle_dl_next = settle_dl_reg;
        retry_dl_next  = retry_dl_reg;
        backoff_next   = backoff_reg;
        attempt        = 1'b0;
        status         = ssched_pkg::ST_IDLE;
        if (item.action == ssched_pkg::ACT_QUEUE)
        begin
            held_next      = item.value_word;
            pending_next   = 1'b1;
            settle_dl_next = settle_sum[TIME_WIDTH-1:0];
            status         = ssched_pkg::ST_QUEUED;
        end
        else if (!pending_reg)
        begin
            status = ssched_pkg::ST_IDLE;
        end
        else if (settle_wait)
        begin
            status = ssched_pkg::ST_SETTLING;
        end
        else if (retry_wait)
        begin
            status = ssched_pkg::ST_BACKING_OFF;
        end
        else if (!item.link_up)
        begin
            retry_dl_next = retry_sum[TIME_WIDTH-1:0];
            backoff_next  = capped;
            status        = ssched_pkg::ST_LINK_DOWN;
        end
        else if (!cfg.destination_set)
        begin
            pending_next = 1'b0;
            status       = ssched_pkg::ST_DROPPED;
        end
        else if (!item.open_ok)
        begin
            retry_dl_next = retry_sum[TIME_WIDTH-1:0];
            backoff_next  = capped;
            status        = ssched_pkg::ST_OPEN_FAILED;
        end
        else if (reply_ok)
        begin
            attempt       = 1'b1;
            pending_next  = 1'b0;
            backoff_next  = cfg.backoff_initial_ms;
            retry_dl_next = now_t;
            status        = ssched_pkg::ST_SENT_OK;
        end
        else
        begin
            attempt       = 1'b1;
            retry_dl_next = retry_sum[TIME_WIDTH-1:0];
            backoff_next  = capped;
            status        = ssched_pkg::ST_BAD_REPLY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 1'b0;
            held_reg      <= '0;
            settle_dl_reg <= '0;
            retry_dl_reg  <= '0;
            backoff_reg   <= ssched_pkg::RST_BACKOFF_INIT;
        end
        else if (fire)
        begin
            pending_reg   <= pending_next;
            held_reg      <= held_next;
            settle_dl_reg <= settle_dl_next;
            retry_dl_reg  <= retry_dl_next;
            backoff_reg   <= backoff_next;
        end
    end

    assign result.status         = status;
    assign result.attempt        = attempt;
    assign result.send_value     = held_next;
    assign result.pending        = pending_next;
    assign result.backoff_now_ms = backoff_next;

    a_attempt_status: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && attempt) |-> (status == ssched_pkg::ST_SENT_OK ||
                               status == ssched_pkg::ST_BAD_REPLY))
        else $error("attempt flagged without a send outcome");

    a_success_restores: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && status == ssched_pkg::ST_SENT_OK) |=>
            (!pending_reg && backoff_reg == $past(cfg.backoff_initial_ms)))
        else $error("success did not clear pending and restore backoff");

    a_queue_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.action == ssched_pkg::ACT_QUEUE) |=>
            (pending_reg && held_reg == $past(item.value_word)))
        else $error("queued value not held");

    a_idle_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> ($stable(pending_reg) && $stable(backoff_reg) && $stable(retry_dl_reg)))
        else $error("state changed without a beat");

endmodule

// File: sv/settle_and_backoff_send_scheduler.sv
`timescale 1ns / 1ps
// Top level of the settle and backoff send scheduler: input register, decision core,
// result register. Depends on ssched_pkg, ssched_if, ssched_cfg and ssched_core.
//
//  channel   direction  handshake      carries
//  items     in         valid/ready    action, now_ms, value_word, link_up, open_ok,
//                                      response_code
//  results   out        valid/ready    status, attempt, send_value, pending, backoff_now_ms
//  cfg       in         cfg_we         cfg_index, cfg_data (no read-back)
//
// One beat is accepted per cycle while results are not stalled; it waits in the input
// register until the result register is free, then its result is offered from there.
// The decision logic between the registers is two adds, two wrap-safe differences, the
// reply range check and a capped doubling, so a beat can follow each unstalled cycle.
// Reset returns the config registers to their defaults and clears state; no clearing pass.
// A stalled result holds the result register; the input register still takes one beat.
module settle_and_backoff_send_scheduler
#(
    parameter int TIME_WIDTH = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    ssched_item_if.sink                         items,
    ssched_result_if.source                     results,
    input  logic                                cfg_we,
    input  logic [ssched_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ssched_pkg::CFG_DATA_W-1:0]   cfg_data
);

    ssched_pkg::cfg_t    cfg;
    ssched_pkg::item_t   item_reg;
    ssched_pkg::result_t result;
    ssched_pkg::result_t result_reg;
    logic                item_valid_reg;
    logic                item_valid_next;
    logic                result_valid_reg;
    logic                result_valid_next;
    logic                advance;
    logic                take;

    assign advance = item_valid_reg && (!result_valid_reg || results.ready);
    assign take    = items.valid && items.ready;
    assign items.ready = !item_valid_reg || advance;

    assign item_valid_next   = take || (item_valid_reg && !advance);
    assign result_valid_next = advance || (result_valid_reg && !results.ready);

    ssched_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ssched_core #(.TIME_WIDTH(TIME_WIDTH)) u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.action        <= items.action;
            item_reg.now_ms        <= items.now_ms;
            item_reg.value_word    <= items.value_word;
            item_reg.link_up       <= items.link_up;
            item_reg.open_ok       <= items.open_ok;
            item_reg.response_code <= items.response_code;
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign results.valid          = result_valid_reg;
    assign results.status         = result_reg.status;
    assign results.attempt        = result_reg.attempt;
    assign results.send_value     = result_reg.send_value;
    assign results.pending        = result_reg.pending;
    assign results.backoff_now_ms = result_reg.backoff_now_ms;

    a_stall_keeps_item: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && result_valid_reg && !results.ready) |=> item_valid_reg)
        else $error("buffered beat lost during an output stall");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("processed beat produced no result");

    a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !advance) |-> !items.ready)
        else $error("input accepted while the input register is held");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for settle_and_backoff_send_scheduler: a queue-fed driver and a
// clocked monitor check every result beat against an in-bench scheduler predictor.
// Depends on ssched_pkg, ssched_if and the scheduler RTL.
module tb;

    import ssched_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    ssched_item_if   item_ch ();
    ssched_result_if result_ch ();

    settle_and_backoff_send_scheduler uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (item_ch),
        .results   (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Scheduler state as the bench expects it to be.
    cfg_t             sched_cfg;
    logic             pend_flag;
    logic [VALUE_W-1:0] pend_value;
    logic [NOW_W-1:0] settle_due;
    logic [NOW_W-1:0] retry_due;
    logic [MS_W-1:0]  retry_window;

    item_t   offered_items[$];
    result_t expected_reports[$];

    logic [NOW_W-1:0] clock_ms;
    int send_idle_pct = 0;
    int out_stall_pct = 0;
    int hold_left = 0;
    int beats_in = 0;
    int reports_checked = 0;
    int mismatches = 0;
    int settings_run = 0;
    int status_seen[9];

    function automatic logic still_waiting(input logic [NOW_W-1:0] now,
                                           input logic [NOW_W-1:0] deadline);
        logic [NOW_W-1:0] diff;
        diff = now - deadline;
        return diff[NOW_W-1];
    endfunction

    function automatic void arm_retry(input logic [NOW_W-1:0] now);
        logic [MS_W:0] doubled;
        doubled = {retry_window, 1'b0};
        retry_due = now + NOW_W'(retry_window);
        if (doubled > {1'b0, sched_cfg.backoff_max_ms})
            doubled = {1'b0, sched_cfg.backoff_max_ms};
        retry_window = doubled[MS_W-1:0];
    endfunction

    function automatic result_t schedule_step(input item_t it);
        result_t r;
        r.attempt = 1'b0;
        if (it.action == ACT_QUEUE)
        begin
            pend_value = it.value_word;
            pend_flag  = 1'b1;
            settle_due = it.now_ms + NOW_W'(sched_cfg.settle_ms);
            r.status   = ST_QUEUED;
        end
        else if (!pend_flag)
            r.status = ST_IDLE;
        else if (still_waiting(it.now_ms, settle_due))
            r.status = ST_SETTLING;
        else if (still_waiting(it.now_ms, retry_due))
            r.status = ST_BACKING_OFF;
        else if (!it.link_up)
        begin
            arm_retry(it.now_ms);
            r.status = ST_LINK_DOWN;
        end
        else if (!sched_cfg.destination_set)
        begin
            pend_flag = 1'b0;
            r.status  = ST_DROPPED;
        end
        else if (!it.open_ok)
        begin
            arm_retry(it.now_ms);
            r.status = ST_OPEN_FAILED;
        end
        else
        begin
            r.attempt = 1'b1;
            if ($signed(it.response_code) >= CODE_OK_LOW &&
                $signed(it.response_code) < CODE_OK_HIGH)
            begin
                pend_flag    = 1'b0;
                retry_window = sched_cfg.backoff_initial_ms;
                retry_due    = it.now_ms;
                r.status     = ST_SENT_OK;
            end
            else
            begin
                arm_retry(it.now_ms);
                r.status = ST_BAD_REPLY;
            end
        end
        r.send_value     = pend_value;
        r.pending        = pend_flag;
        r.backoff_now_ms = retry_window;
        return r;
    endfunction

    // Mostly forward-moving time with a mix of step sizes, so that settle and backoff
    // windows expire at every scale; a few jumps land anywhere, wrap included.
    function automatic item_t random_item();
        item_t       it;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 30)
            clock_ms += $urandom_range(8);
        else if (pick < 60)
            clock_ms += $urandom_range(4000);
        else if (pick < 85)
            clock_ms += $urandom_range(70000);
        else if (pick < 95)
            clock_ms += $urandom_range(32'h0200_0000);
        else
            clock_ms = $urandom;
        it.action     = ($urandom_range(99) < 15) ? ACT_QUEUE : ACT_TICK;
        it.now_ms     = clock_ms;
        it.value_word = $urandom;
        it.link_up    = ($urandom_range(99) < 85);
        it.open_ok    = ($urandom_range(99) < 85);
        pick = $urandom_range(99);
        if (pick < 60)
            it.response_code = CODE_W'($urandom_range(299, 200));
        else if (pick < 65)
            it.response_code = CODE_OK_LOW - 11'sd1;
        else if (pick < 70)
            it.response_code = CODE_OK_HIGH;
        else
            it.response_code = CODE_W'($urandom);
        return it;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_SETTLE_MS:    sched_cfg.settle_ms          = data;
            REG_BACKOFF_INIT: sched_cfg.backoff_initial_ms = data;
            REG_BACKOFF_MAX:  sched_cfg.backoff_max_ms     = data;
            REG_DESTINATION:  sched_cfg.destination_set    = data[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input bit after_reset, input logic [MS_W-1:0] settle,
                             input logic [MS_W-1:0] init, input logic [MS_W-1:0] cap,
                             input logic dest, input int send_pct, input int stall_pct,
                             input int hold, input int count);
        int i;
        if (!after_reset)
        begin
            write_reg(REG_SETTLE_MS, settle);
            write_reg(REG_BACKOFF_INIT, init);
            write_reg(REG_BACKOFF_MAX, cap);
            write_reg(REG_DESTINATION, {23'($urandom), dest});
        end
        settings_run++;
        @(negedge clk);
        send_idle_pct = send_pct;
        out_stall_pct = stall_pct;
        hold_left     = hold;
        if (after_reset)
        begin
            // Idle tick, latest value wins, settling, link down, backing off, open failure,
            // bad replies at the code extremes up to the backoff cap, success, wrapped
            // settle deadline, backing off across the wrap, then a send.
            offered_items.push_back(item_t'{ACT_TICK, 32'd0, 32'd0, 1'b1, 1'b1, 11'sd200});
            offered_items.push_back(item_t'{ACT_QUEUE, 32'h100, 32'hFFFF_FFFF, 1'b0, 1'b0,
                                            11'h400});
            offered_items.push_back(item_t'{ACT_QUEUE, 32'h200, 32'hA5A5_5A5A, 1'b1, 1'b1,
                                            11'h3FF});
            offered_items.push_back(item_t'{ACT_TICK, 32'h300, 32'd0, 1'b1, 1'b1, 11'sd200});
            offered_items.push_back(item_t'{ACT_TICK, 32'd2512, 32'd0, 1'b0, 1'b1, 11'sd200});
            offered_items.push_back(item_t'{ACT_TICK, 32'd2512, 32'd0, 1'b1, 1'b1, 11'sd200});
            offered_items.push_back(item_t'{ACT_TICK, 32'd102512, 32'd0, 1'b1, 1'b0,
                                            11'sd200});
            offered_items.push_back(item_t'{ACT_TICK, 32'd202512, 32'd0, 1'b1, 1'b1,
                                            11'sd199});
            offered_items.push_back(item_t'{ACT_TICK, 32'd302512, 32'd0, 1'b1, 1'b1,
                                            11'sd300});
            offered_items.push_back(item_t'{ACT_TICK, 32'd402512, 32'd0, 1'b1, 1'b1, 11'h400});
            offered_items.push_back(item_t'{ACT_TICK, 32'd502512, 32'd0, 1'b1, 1'b1, 11'h3FF});
            offered_items.push_back(item_t'{ACT_TICK, 32'd602512, 32'd0, 1'b1, 1'b1,
                                            11'sd200});
            offered_items.push_back(item_t'{ACT_TICK, 32'd702512, 32'hFFFF_FFFF, 1'b1, 1'b1,
                                            11'sd200});
            offered_items.push_back(item_t'{ACT_QUEUE, 32'hFFFF_FC00, 32'd0, 1'b1, 1'b1,
                                            11'sd200});
            offered_items.push_back(item_t'{ACT_TICK, 32'hFFFF_FFFF, 32'd0, 1'b1, 1'b1,
                                            11'sd200});
            offered_items.push_back(item_t'{ACT_TICK, 32'h0000_03D0, 32'd0, 1'b1, 1'b1,
                                            11'sd200});
            offered_items.push_back(item_t'{ACT_TICK, 32'h7FFF_FFFF, 32'd0, 1'b1, 1'b1,
                                            11'sd299});
            clock_ms = 32'h8000_0000;
        end
        for (i = 0; i < count; i++)
            offered_items.push_back(random_item());
        while (offered_items.size() != 0 || item_ch.valid || expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic flag_mismatch(input string field, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            item_ch.valid <= 1'b0;
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                expected_reports.push_back(schedule_step(item_t'{item_ch.action,
                    item_ch.now_ms, item_ch.value_word, item_ch.link_up, item_ch.open_ok,
                    item_ch.response_code}));
                void'(offered_items.pop_front());
                beats_in++;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (offered_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item_ch.valid         <= 1'b1;
                    item_ch.action        <= offered_items[0].action;
                    item_ch.now_ms        <= offered_items[0].now_ms;
                    item_ch.value_word    <= offered_items[0].value_word;
                    item_ch.link_up       <= offered_items[0].link_up;
                    item_ch.open_ok       <= offered_items[0].open_ok;
                    item_ch.response_code <= offered_items[0].response_code;
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = result_t'{result_ch.status, result_ch.attempt, result_ch.send_value,
                            result_ch.pending, result_ch.backoff_now_ms};
            if (expected_reports.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, expected none, actual %p",
                         $time, got);
                mismatches++;
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got.status !== want.status)
                    flag_mismatch("status", want.status, got.status);
                if (got.attempt !== want.attempt)
                    flag_mismatch("attempt", want.attempt, got.attempt);
                if (got.send_value !== want.send_value)
                    flag_mismatch("send_value", want.send_value, got.send_value);
                if (got.pending !== want.pending)
                    flag_mismatch("pending", want.pending, got.pending);
                if (got.backoff_now_ms !== want.backoff_now_ms)
                    flag_mismatch("backoff_now_ms", want.backoff_now_ms, got.backoff_now_ms);
                status_seen[want.status]++;
                reports_checked++;
            end
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = REG_SETTLE_MS;
        cfg_data              = '0;
        item_ch.valid         = 1'b0;
        item_ch.action        = ACT_TICK;
        item_ch.now_ms        = '0;
        item_ch.value_word    = '0;
        item_ch.link_up       = 1'b0;
        item_ch.open_ok       = 1'b0;
        item_ch.response_code = '0;
        result_ch.ready       = 1'b0;
        sched_cfg    = cfg_t'{RST_SETTLE_MS, RST_BACKOFF_INIT, RST_BACKOFF_MAX,
                              RST_DESTINATION};
        pend_flag    = 1'b0;
        pend_value   = '0;
        settle_due   = '0;
        retry_due    = '0;
        retry_window = RST_BACKOFF_INIT;
        clock_ms     = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        run_phase(1'b1, '0, '0, '0, 1'b1, 0, 0, 0, 190);
        run_phase(1'b0, 24'd0, 24'd1, 24'd1, 1'b1, 82, 0, 0, 160);
        run_phase(1'b0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 0, 82, 0, 160);
        run_phase(1'b0, 24'd10, 24'd0, 24'd5, 1'b1, 11, 11, 0, 160);
        run_phase(1'b0, 24'd500, 24'd20000, 24'd3000, 1'b1, 0, 0, 0, 160);
        run_phase(1'b0, 24'd100, 24'd50, 24'd100000, 1'b0, 0, 0, 300, 160);

        $display("Checked %0d results for %0d input beats over %0d register settings,",
                 reports_checked, beats_in, settings_run);
        $display("statuses idle..queued seen %0d %0d %0d %0d %0d %0d %0d %0d %0d times.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6], status_seen[7],
                 status_seen[8]);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("** settle_and_backoff_send_scheduler: PASSED **");
        else
            $display("** settle_and_backoff_send_scheduler: FAILED **");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results still expected.", expected_reports.size());
        $display("** settle_and_backoff_send_scheduler: FAILED **");
        $finish;
    end

endmodule
